@@ rtl/swd_pkg.sv @@
`default_nettype none

package swd_pkg;

    // Fixed field widths
    localparam int PAD_COUNT  = 3;
    localparam int TIME_BITS  = 32;
    localparam int LEVEL_BITS = 8;
    localparam int GAP_BITS   = 16;
    localparam int CMP_BITS   = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GAP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_GAP = 2'd1;

    // Register reset values
    localparam logic [GAP_BITS-1:0] MIN_GAP_RESET = 16'd30;
    localparam logic [GAP_BITS-1:0] MAX_GAP_RESET = 16'd400;

    // Swipe direction codes
    localparam logic [1:0] DIR_NONE     = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;

    // Pad indexes, front to back
    localparam int PAD_FRONT  = 0;
    localparam int PAD_MIDDLE = 1;
    localparam int PAD_BACK   = 2;

    // What one pad lane reports for the current poll
    typedef struct packed {
        logic                 hit;
        logic                 touched;
        logic [TIME_BITS-1:0] start;
    } lane_t;

endpackage

`default_nettype wire

@@ rtl/swd_pad_lane.sv @@
`default_nettype none

module swd_pad_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic                          release_all,
    input  wire logic [swd_pkg::LEVEL_BITS-1:0] level,
    input  wire logic [swd_pkg::TIME_BITS-1:0]  now,
    output swd_pkg::lane_t                     lane
);

    logic                          touched_reg;
    logic                          touched_next;
    logic [swd_pkg::TIME_BITS-1:0] start_reg;
    logic [swd_pkg::TIME_BITS-1:0] start_next;
    logic                          hit;

    // Mark the pad and latch its first-touch time
    always_comb
    begin
        hit          = (level != '0);
        lane.hit     = hit;
        lane.touched = touched_reg | hit;
        lane.start   = (hit && !touched_reg) ? now : start_reg;
        touched_next = release_all ? 1'b0 : lane.touched;
        start_next   = lane.start;
    end

    // Advance lane state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= 1'b0;
            start_reg   <= '0;
        end
        else if (take)
        begin
            touched_reg <= touched_next;
            start_reg   <= start_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/swd_merge.sv @@
`default_nettype none

module swd_merge (
    input  wire swd_pkg::lane_t                lanes [swd_pkg::PAD_COUNT],
    input  wire logic                          latched,
    input  wire logic [swd_pkg::GAP_BITS-1:0]  min_gap,
    input  wire logic [swd_pkg::GAP_BITS-1:0]  max_gap,
    output logic [1:0]                         dir
);

    logic [swd_pkg::TIME_BITS-1:0] gap_f1;
    logic [swd_pkg::TIME_BITS-1:0] gap_f2;
    logic [swd_pkg::TIME_BITS-1:0] gap_b1;
    logic [swd_pkg::TIME_BITS-1:0] gap_b2;
    logic                          ok_f1;
    logic                          ok_f2;
    logic                          ok_b1;
    logic                          ok_b2;
    logic                          all_touched;
    logic                          any_hit;

    // Check one signed gap against the open window (min, max)
    function automatic logic gap_ok(
        input logic [swd_pkg::TIME_BITS-1:0] gap,
        input logic [swd_pkg::GAP_BITS-1:0]  lo,
        input logic [swd_pkg::GAP_BITS-1:0]  hi
    );
        logic [swd_pkg::CMP_BITS-1:0] g;
        logic [swd_pkg::CMP_BITS-1:0] l;
        logic [swd_pkg::CMP_BITS-1:0] h;
        begin
            g = swd_pkg::CMP_BITS'(gap);
            l = swd_pkg::CMP_BITS'(lo);
            h = swd_pkg::CMP_BITS'(hi);
            gap_ok = !gap[swd_pkg::TIME_BITS-1] && (g > l) && (g < h);
        end
    endfunction

    // Wrapping differences between start times
    always_comb
    begin
        gap_f1 = lanes[swd_pkg::PAD_MIDDLE].start - lanes[swd_pkg::PAD_FRONT].start;
        gap_f2 = lanes[swd_pkg::PAD_BACK].start   - lanes[swd_pkg::PAD_MIDDLE].start;
        gap_b1 = lanes[swd_pkg::PAD_MIDDLE].start - lanes[swd_pkg::PAD_BACK].start;
        gap_b2 = lanes[swd_pkg::PAD_FRONT].start  - lanes[swd_pkg::PAD_MIDDLE].start;
        ok_f1  = gap_ok(gap_f1, min_gap, max_gap);
        ok_f2  = gap_ok(gap_f2, min_gap, max_gap);
        ok_b1  = gap_ok(gap_b1, min_gap, max_gap);
        ok_b2  = gap_ok(gap_b2, min_gap, max_gap);
    end

    // Combine lanes into a direction, forward first; a poll with no touch, or a latched gesture, reports none
    always_comb
    begin
        all_touched = lanes[swd_pkg::PAD_FRONT].touched
                    & lanes[swd_pkg::PAD_MIDDLE].touched
                    & lanes[swd_pkg::PAD_BACK].touched;
        any_hit     = lanes[swd_pkg::PAD_FRONT].hit
                    | lanes[swd_pkg::PAD_MIDDLE].hit
                    | lanes[swd_pkg::PAD_BACK].hit;
        dir = swd_pkg::DIR_NONE;
        if (all_touched && any_hit && !latched)
        begin
            if (ok_f1 && ok_f2)
            begin
                dir = swd_pkg::DIR_FORWARD;
            end
            else if (ok_b1 && ok_b2)
            begin
                dir = swd_pkg::DIR_BACKWARD;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/three_pad_swipe_detector_core.sv @@
`default_nettype none

// Three-pad swipe detector. One poll (pad levels plus a millisecond time) can be
// accepted every cycle while in_stall is low, and its result (swipe_dir, any_touch)
// is registered in the output register, or in the skid entry while that register
// is held. Three pad lanes mark touches and latch first-touch times in parallel; a
// combinational merge stage forms the wrapping gaps and checks them against min_gap
// and max_gap. An output register with one skid entry sits between the sides, so
// in_stall comes from a flop and rises only when two results wait unclaimed.
// Configuration is always ready; write it only while no poll is in flight.
module three_pad_swipe_detector_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [swd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [swd_pkg::GAP_BITS-1:0]       cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [swd_pkg::LEVEL_BITS-1:0]     pad_front_level,
    input  wire logic [swd_pkg::LEVEL_BITS-1:0]     pad_middle_level,
    input  wire logic [swd_pkg::LEVEL_BITS-1:0]     pad_back_level,
    input  wire logic [31:0]                        now_ms,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              swipe_dir,
    output logic                                    any_touch
);

    logic [swd_pkg::GAP_BITS-1:0]   min_gap_reg;
    logic [swd_pkg::GAP_BITS-1:0]   max_gap_reg;
    logic                           latched_reg;
    logic                           latched_next;
    logic                           out_valid_reg;
    logic [1:0]                     out_dir_reg;
    logic                           out_any_reg;
    logic                           skid_valid_reg;
    logic [1:0]                     skid_dir_reg;
    logic                           skid_any_reg;
    logic                           in_fire;
    logic                           out_fire;
    logic                           any_hit;
    logic [1:0]                     dir;
    logic [swd_pkg::LEVEL_BITS-1:0] levels [swd_pkg::PAD_COUNT];
    swd_pkg::lane_t                 lanes  [swd_pkg::PAD_COUNT];

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign swipe_dir = out_dir_reg;
    assign any_touch = out_any_reg;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= swd_pkg::MIN_GAP_RESET;
            max_gap_reg <= swd_pkg::MAX_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swd_pkg::REG_MIN_GAP: min_gap_reg <= cfg_data;
                swd_pkg::REG_MAX_GAP: max_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign levels[swd_pkg::PAD_FRONT]  = pad_front_level;
    assign levels[swd_pkg::PAD_MIDDLE] = pad_middle_level;
    assign levels[swd_pkg::PAD_BACK]   = pad_back_level;

    // One lane per pad
    for (genvar i = 0; i < swd_pkg::PAD_COUNT; i++)
    begin : g_lane
        swd_pad_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .take        (in_fire),
            .release_all (!any_hit),
            .level       (levels[i]),
            .now         (now_ms[swd_pkg::TIME_BITS-1:0]),
            .lane        (lanes[i])
        );
    end

    assign any_hit = lanes[swd_pkg::PAD_FRONT].hit
                   | lanes[swd_pkg::PAD_MIDDLE].hit
                   | lanes[swd_pkg::PAD_BACK].hit;

    swd_merge u_merge (
        .lanes   (lanes),
        .latched (latched_reg),
        .min_gap (min_gap_reg),
        .max_gap (max_gap_reg),
        .dir     (dir)
    );

    // Gesture latch: set on a report, drop when all pads release
    assign latched_next = any_hit ? (latched_reg || (dir != swd_pkg::DIR_NONE)) : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            latched_reg <= latched_next;
        end
    end

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves with the control above
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_dir_reg <= skid_dir_reg;
                out_any_reg <= skid_any_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_dir_reg <= dir;
                skid_any_reg <= any_hit;
            end
            else
            begin
                out_dir_reg <= dir;
                out_any_reg <= any_hit;
            end
        end
    end

    // A reported swipe always comes with a touch
    a_dir_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (swipe_dir != swd_pkg::DIR_NONE) |-> any_touch)
        else $error("swipe reported without a touch");

    // The skid entry is only filled behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // A report latches the gesture
    a_report_latches: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (dir != swd_pkg::DIR_NONE) |=> latched_reg)
        else $error("gesture latch not set after a report");

    // A poll with no touch clears the latch and every stored mark
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !any_hit |=> !latched_reg
            && (lanes[swd_pkg::PAD_FRONT].hit || !lanes[swd_pkg::PAD_FRONT].touched)
            && (lanes[swd_pkg::PAD_MIDDLE].hit || !lanes[swd_pkg::PAD_MIDDLE].touched)
            && (lanes[swd_pkg::PAD_BACK].hit || !lanes[swd_pkg::PAD_BACK].touched))
        else $error("release poll left state set");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CHUNK_POLLS = 52;

    // Indexes past the register list; writes to them must have no effect
    localparam logic [swd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [swd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef logic [swd_pkg::PAD_COUNT-1:0][swd_pkg::LEVEL_BITS-1:0] pad_levels_t;

    typedef struct packed {
        pad_levels_t   level;
        logic [31:0]   now;
    } poll_t;

    typedef struct packed {
        logic [1:0] dir;
        logic       touch;
    } swipe_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [swd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [swd_pkg::GAP_BITS-1:0]       cfg_data = '0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [swd_pkg::LEVEL_BITS-1:0] pad_front_level = '0;
    logic [swd_pkg::LEVEL_BITS-1:0] pad_middle_level = '0;
    logic [swd_pkg::LEVEL_BITS-1:0] pad_back_level = '0;
    logic [31:0]                    now_ms = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] swipe_dir;
    logic       any_touch;

    // Polls waiting to be driven and swipe results waiting to come out
    poll_t  pending_polls[$];
    swipe_t expected_swipes[$];

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Shadow of the detector state and its gap window
    logic [swd_pkg::GAP_BITS-1:0]        gap_floor = swd_pkg::MIN_GAP_RESET;
    logic [swd_pkg::GAP_BITS-1:0]        gap_ceiling = swd_pkg::MAX_GAP_RESET;
    logic [swd_pkg::PAD_COUNT-1:0]       pad_held = '0;
    logic [swd_pkg::PAD_COUNT-1:0][31:0] pad_first_ms = '0;
    logic                                swipe_locked = 1'b0;

    three_pad_swipe_detector_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pad_front_level  (pad_front_level),
        .pad_middle_level (pad_middle_level),
        .pad_back_level   (pad_back_level),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .swipe_dir        (swipe_dir),
        .any_touch        (any_touch)
    );

    always #6 clk = ~clk;

    // Signed wrapping difference later - earlier over the full time width
    function automatic int gap_ms(input logic [31:0] later, input logic [31:0] earlier);
        return int'(later - earlier);
    endfunction

    function automatic bit in_window(input int gap);
        return gap > int'(gap_floor) && gap < int'(gap_ceiling);
    endfunction

    // Advance the shadow state by one poll and return the swipe it reports
    function automatic swipe_t predict_swipe(input poll_t p);
        swipe_t r;
        r.dir   = swd_pkg::DIR_NONE;
        r.touch = (p.level != '0);
        for (int i = 0; i < swd_pkg::PAD_COUNT; i++)
        begin
            if (p.level[i] != '0 && !pad_held[i])
            begin
                pad_held[i]     = 1'b1;
                pad_first_ms[i] = p.now;
            end
        end
        if (!r.touch)
        begin
            swipe_locked = 1'b0;
            pad_held     = '0;
        end
        else if (&pad_held && !swipe_locked)
        begin
            if (in_window(gap_ms(pad_first_ms[swd_pkg::PAD_MIDDLE],
                                 pad_first_ms[swd_pkg::PAD_FRONT])) &&
                in_window(gap_ms(pad_first_ms[swd_pkg::PAD_BACK],
                                 pad_first_ms[swd_pkg::PAD_MIDDLE])))
            begin
                r.dir        = swd_pkg::DIR_FORWARD;
                swipe_locked = 1'b1;
            end
            else if (in_window(gap_ms(pad_first_ms[swd_pkg::PAD_MIDDLE],
                                      pad_first_ms[swd_pkg::PAD_BACK])) &&
                     in_window(gap_ms(pad_first_ms[swd_pkg::PAD_FRONT],
                                      pad_first_ms[swd_pkg::PAD_MIDDLE])))
            begin
                r.dir        = swd_pkg::DIR_BACKWARD;
                swipe_locked = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic pad_levels_t pads(input logic [7:0] front, input logic [7:0] middle,
                                         input logic [7:0] back);
        pad_levels_t lv;
        lv[swd_pkg::PAD_FRONT]  = front;
        lv[swd_pkg::PAD_MIDDLE] = middle;
        lv[swd_pkg::PAD_BACK]   = back;
        return lv;
    endfunction

    function automatic void push_poll(input pad_levels_t lv, input logic [31:0] t);
        poll_t p;
        p.level = lv;
        p.now   = t;
        pending_polls.push_back(p);
    endfunction

    function automatic logic [7:0] touch_level();
        case ($urandom_range(3))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    // Pick a gap at or next to the window edges half of the time
    function automatic logic [31:0] pick_gap();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = 32'(gap_floor);
        hi = 32'(gap_ceiling);
        case ($urandom_range(9))
            0: return lo;
            1: return lo + 1;
            2: return hi - 1;
            3: return hi;
            4: return hi + 1;
            5: return '0;
            6: return $urandom();
            default:
            begin
                if (hi > lo + 1)
                    return $urandom_range(hi - 1, lo + 1);
                return $urandom_range(65535);
            end
        endcase
    endfunction

    // Queue one swipe attempt with random content; returns the polls added
    function automatic int queue_swipe(input bit backward);
        int          lead;
        int          tail;
        int          count;
        logic [31:0] t;
        logic [31:0] g1;
        logic [31:0] g2;
        pad_levels_t lv;
        lead  = backward ? swd_pkg::PAD_BACK : swd_pkg::PAD_FRONT;
        tail  = backward ? swd_pkg::PAD_FRONT : swd_pkg::PAD_BACK;
        t     = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(1000) : $urandom();
        g1    = pick_gap();
        g2    = pick_gap();
        count = 0;
        lv    = '0;
        // Release first, but now and then keep marks from before
        if ($urandom_range(7) != 0)
        begin
            push_poll(lv, t - 1);
            count++;
        end
        lv[lead] = touch_level();
        push_poll(lv, t);
        count++;
        if ($urandom_range(2) == 0)
        begin
            lv[lead] = touch_level();
            push_poll(lv, t + (g1 >> 1));
            count++;
        end
        lv[swd_pkg::PAD_MIDDLE] = touch_level();
        if ($urandom_range(3) == 0)
            lv[lead] = '0;
        push_poll(lv, t + g1);
        count++;
        lv[tail] = touch_level();
        if ($urandom_range(3) == 0)
            lv[swd_pkg::PAD_MIDDLE] = '0;
        push_poll(lv, t + g1 + g2);
        count++;
        // Hold or partly release after the attempt
        repeat ($urandom_range(2))
        begin
            lv[$urandom_range(swd_pkg::PAD_COUNT - 1)] = $urandom_range(1) ? touch_level()
                                                                          : 8'd0;
            push_poll(lv, t + g1 + g2 + $urandom_range(500));
            count++;
        end
        return count;
    endfunction

    function automatic int queue_noise();
        int          n;
        logic [31:0] t;
        pad_levels_t lv;
        n = $urandom_range(4, 1);
        t = $urandom();
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < swd_pkg::PAD_COUNT; i++)
                lv[i] = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255));
            t = $urandom_range(1) ? $urandom() : t + $urandom_range(600);
            push_poll(lv, t);
        end
        return n;
    endfunction

    function automatic void queue_random(input int polls);
        int made;
        made = 0;
        while (made < polls)
        begin
            if ($urandom_range(9) < 7)
                made += queue_swipe($urandom_range(1));
            else
                made += queue_noise();
        end
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
            IDLE_BOTH:     begin send_idle_pct = 24; stall_pct = 24; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    // Write one register and mirror it in the shadow window
    task automatic write_cfg(input logic [swd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [swd_pkg::GAP_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            swd_pkg::REG_MIN_GAP: gap_floor = val;
            swd_pkg::REG_MAX_GAP: gap_ceiling = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued poll has gone in and every result come out;
    // sample between edges so the driver and monitor updates have settled
    task automatic settle();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || in_valid || expected_swipes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Poll driver: predict on each transfer, hold while stalled, then load the next
    always @(posedge clk)
    begin
        poll_t taken;
        poll_t next_poll;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.level = pads(pad_front_level, pad_middle_level, pad_back_level);
                taken.now   = now_ms;
                expected_swipes.push_back(predict_swipe(taken));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_poll = pending_polls.pop_front();
                    in_valid         <= 1'b1;
                    pad_front_level  <= next_poll.level[swd_pkg::PAD_FRONT];
                    pad_middle_level <= next_poll.level[swd_pkg::PAD_MIDDLE];
                    pad_back_level   <= next_poll.level[swd_pkg::PAD_BACK];
                    now_ms           <= next_poll.now;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        swipe_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_swipes.size() == 0)
            begin
                $error("unexpected result: swipe_dir %0d any_touch %0d", swipe_dir, any_touch);
                fail_count++;
            end
            else
            begin
                want = expected_swipes.pop_front();
                if (swipe_dir !== want.dir)
                begin
                    $error("swipe_dir mismatch: expected %0d, actual %0d", want.dir, swipe_dir);
                    fail_count++;
                end
                if (any_touch !== want.touch)
                begin
                    $error("any_touch mismatch: expected %0d, actual %0d", want.touch, any_touch);
                    fail_count++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
                   expected_swipes.size());
            $display("three_pad_swipe_detector_core test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed polls under the reset window
        set_idle(IDLE_NONE);
        push_poll(pads(0, 0, 0), 32'd0);
        // all pads on one poll: zero gaps never qualify
        push_poll(pads(255, 255, 255), 32'hFFFF_FFFF);
        push_poll(pads(0, 0, 0), 32'd5);
        // forward just inside the window, marks persist through partial release
        push_poll(pads(1, 0, 0), 32'd100);
        push_poll(pads(1, 128, 0), 32'd131);
        push_poll(pads(0, 0, 1), 32'd162);
        // latched gesture stays quiet until release
        push_poll(pads(255, 255, 255), 32'd170);
        push_poll(pads(0, 0, 0), 32'd171);
        // backward across the time wrap
        push_poll(pads(0, 0, 255), 32'hFFFF_FF00);
        push_poll(pads(0, 7, 255), 32'hFFFF_FF00 + 32'd399);
        push_poll(pads(200, 7, 0), 32'hFFFF_FF00 + 32'd798);
        push_poll(pads(0, 0, 0), 32'd0);
        // gaps equal to the floor
        push_poll(pads(1, 0, 0), 32'd1000);
        push_poll(pads(1, 1, 0), 32'd1030);
        push_poll(pads(1, 1, 1), 32'd1060);
        push_poll(pads(0, 0, 0), 32'd1061);
        // gaps equal to the ceiling
        push_poll(pads(1, 0, 0), 32'd2000);
        push_poll(pads(1, 1, 0), 32'd2400);
        push_poll(pads(1, 1, 1), 32'd2800);
        push_poll(pads(0, 0, 0), 32'd2801);
        // time running backward turns a front-first touch into a backward swipe
        push_poll(pads(9, 0, 0), 32'd5000);
        push_poll(pads(9, 9, 0), 32'd4900);
        push_poll(pads(9, 9, 9), 32'd4800);
        push_poll(pads(0, 0, 0), 32'd4801);
        // two marks only, then release
        push_poll(pads(3, 3, 0), 32'd6000);
        push_poll(pads(0, 0, 0), 32'd6100);
        settle();

        // Random polls under several windows, each across every idle pattern
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0:
                begin
                    write_cfg(swd_pkg::REG_MIN_GAP, '0);
                    write_cfg(swd_pkg::REG_MAX_GAP, '1);
                end
                1:
                begin
                    write_cfg(swd_pkg::REG_MIN_GAP, '1);
                    write_cfg(swd_pkg::REG_MAX_GAP, '0);
                    write_cfg(REG_SPARE_A, 16'($urandom()));
                end
                2:
                begin
                    write_cfg(swd_pkg::REG_MIN_GAP, 16'd100);
                    write_cfg(swd_pkg::REG_MAX_GAP, 16'd100);
                    write_cfg(REG_SPARE_B, 16'($urandom()));
                end
                3:
                begin
                    write_cfg(swd_pkg::REG_MIN_GAP, 16'd10);
                    write_cfg(swd_pkg::REG_MAX_GAP, 16'd60);
                end
                4:
                begin
                    write_cfg(swd_pkg::REG_MIN_GAP, 16'($urandom_range(300)));
                    write_cfg(swd_pkg::REG_MAX_GAP, 16'($urandom_range(65535, 200)));
                end
                default:
                begin
                    write_cfg(REG_SPARE_A, 16'($urandom()));
                    write_cfg(swd_pkg::REG_MIN_GAP, swd_pkg::MIN_GAP_RESET);
                    write_cfg(swd_pkg::REG_MAX_GAP, swd_pkg::MAX_GAP_RESET);
                    write_cfg(REG_SPARE_B, 16'($urandom()));
                end
            endcase
            for (int m = 0; m < 4; m++)
            begin
                set_idle(idle_mode_t'(m));
                queue_random(CHUNK_POLLS);
                settle();
            end
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("three_pad_swipe_detector_core test passed");
        else
            $display("three_pad_swipe_detector_core test failed");
        $finish;
    end

endmodule
